@@ hdl/shell_sort_sedgewick_gaps_unit_assert.svh @@
// assertion macros shared by the shell sort unit
`ifndef SHELL_SORT_SEDGEWICK_GAPS_UNIT_ASSERT_SVH
`define SHELL_SORT_SEDGEWICK_GAPS_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SHSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/shsg_pkg.sv @@
// package: sizes, gap function, sequencer states and step unit result
`default_nettype none
package shsg_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	// gap indices considered; the third gap (77) already exceeds any batch count
	localparam int GAP_NUM   = 3;
	localparam int KIDX_W    = 2;
	localparam int GAP_W     = 10;

	typedef enum logic [3:0] {
		S_LOAD,
		S_PLAN,
		S_NEXT,
		S_HOLD,
		S_CMP,
		S_PUT,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_OUT
	} shsg_state_t;

	// result of one compare-and-step of the insertion walk
	typedef struct packed {
		logic              less;
		logic [ADDR_W-1:0] j_dn;
		logic              j_dn_ge;
		logic [ADDR_W-1:0] j_dn2;
	} shsg_step_t;

	// sedgewick gap 4^(k+1) + 3*2^k + 1 built from shifts
	function automatic logic [GAP_W-1:0] gap_of(input logic [KIDX_W-1:0] k);
		logic [GAP_W-1:0] p4;
		logic [GAP_W-1:0] p2;
		p4 = GAP_W'(1) << ({1'b0, k, 1'b0} + 4'd2);
		p2 = GAP_W'(1) << k;
		return p4 + (p2 << 1) + p2 + GAP_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ hdl/shsg_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module shsg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ hdl/shsg_step.sv @@
// shared compare and index step unit of the gapped insertion walk
`default_nettype none
module shsg_step (
	input  wire logic [shsg_pkg::DATA_W-1:0] held,
	input  wire logic [shsg_pkg::DATA_W-1:0] cand,
	input  wire logic [shsg_pkg::ADDR_W-1:0] j,
	input  wire logic [shsg_pkg::CNT_W-1:0]  gap,
	output shsg_pkg::shsg_step_t             res
);
	import shsg_pkg::*;

	logic [CNT_W-1:0] jd_w;
	logic [CNT_W-1:0] jd2_w;

	// signed compare and two gap steps down from j
	always_comb begin
		jd_w        = CNT_W'(j) - gap;
		jd2_w       = jd_w - gap;
		res.less    = $signed(held) < $signed(cand);
		res.j_dn    = jd_w[ADDR_W-1:0];
		res.j_dn_ge = jd_w >= gap;
		res.j_dn2   = jd2_w[ADDR_W-1:0];
	end

endmodule
`default_nettype wire

@@ hdl/shell_sort_sedgewick_gaps_unit.sv @@
// top level: batch loader, shell sort sequencer and result emitter
//
// channel  dir  tdata             tlast      tuser
// s_*      in   value[31:0]       is_last    -
// m_*      out  sorted_value[31:0] is_final  overflow
//
// loading takes one cycle per item; s_tready is low from the last item until
// the final result of the batch has been taken.
// sorting reads and holds each element of a pass, shifts larger ones one gap
// up and writes it in place; passes use gaps 23, 8 (when below the count) and
// then 1. each result is then read from the store and held until taken.
// asynchronous reset clears the control state; the store needs no clearing.
`default_nettype none
`include "shell_sort_sedgewick_gaps_unit_assert.svh"
module shell_sort_sedgewick_gaps_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [shsg_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
	input  wire logic                         s_tlast,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [shsg_pkg::DATA_W-1:0]  m_tdata,   // [31:0] sorted_value
	output logic                              m_tlast,
	output logic                              m_tuser    // [0] overflow
);
	import shsg_pkg::*;

	shsg_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              ovf_q, ovf_d;
	logic [KIDX_W-1:0] kidx_q, kidx_d;
	logic [CNT_W-1:0]  gap_q, gap_d;
	logic [CNT_W-1:0]  i_q, i_d;
	logic [ADDR_W-1:0] j_q, j_d;
	logic [ADDR_W-1:0] e_q, e_d;
	logic [DATA_W-1:0] held_q, held_d;
	logic              m_valid_q, m_valid_d;
	logic [DATA_W-1:0] m_data_q, m_data_d;
	logic              m_last_q, m_last_d;
	logic              m_user_q, m_user_d;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	shsg_step_t        step;
	logic [KIDX_W-1:0] npass;
	logic [GAP_W-1:0]  plan_gap_w;
	logic [GAP_W-1:0]  next_gap_w;
	logic [KIDX_W-1:0] kidx_dn;
	logic [CNT_W-1:0]  i_dn_w;

	// element store
	shsg_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared compare and step unit
	shsg_step u_step (
		.held(held_q),
		.cand(ram_rdata),
		.j   (j_q),
		.gap (gap_q),
		.res (step)
	);

	// number of sedgewick gaps below the batch count
	always_comb begin
		npass = '0;
		for (int k = 0; k < GAP_NUM; k++) begin
			if (gap_of(KIDX_W'(k)) < GAP_W'(cnt_q)) begin
				npass = npass + KIDX_W'(1);
			end
		end
		kidx_dn    = kidx_q - KIDX_W'(1);
		plan_gap_w = gap_of(npass - KIDX_W'(1));
		next_gap_w = gap_of(kidx_dn);
		i_dn_w     = i_q - gap_q;
	end

	// state and data registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			ovf_q     <= ovf_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		kidx_q   <= kidx_d;
		gap_q    <= gap_d;
		i_q      <= i_d;
		j_q      <= j_d;
		e_q      <= e_d;
		held_q   <= held_d;
		m_data_q <= m_data_d;
		m_last_q <= m_last_d;
		m_user_q <= m_user_d;
	end

	// sequencer: next state, ram controls and register updates
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		ovf_d     = ovf_q;
		kidx_d    = kidx_q;
		gap_d     = gap_q;
		i_d       = i_q;
		j_d       = j_q;
		e_d       = e_q;
		held_d    = held_q;
		m_valid_d = m_valid_q;
		m_data_d  = m_data_q;
		m_last_d  = m_last_q;
		m_user_d  = m_user_q;
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = held_q;
		ram_raddr = i_q[ADDR_W-1:0];
		s_tready  = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (cnt_q < CNT_W'(MAX_ITEMS)) begin
						ram_we    = 1'b1;
						ram_waddr = cnt_q[ADDR_W-1:0];
						ram_wdata = s_tdata;
						cnt_d     = cnt_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (s_tlast) begin
						state_d = S_PLAN;
					end
				end
			end
			S_PLAN: begin
				// start with the largest gap below the count, or gap 1
				if (npass == '0) begin
					kidx_d = '0;
					gap_d  = CNT_W'(1);
				end else begin
					kidx_d = npass - KIDX_W'(1);
					gap_d  = plan_gap_w[CNT_W-1:0];
				end
				i_d     = gap_d;
				state_d = S_NEXT;
			end
			S_NEXT: begin
				if (i_q >= cnt_q) begin
					// pass done: next smaller gap or emission
					if (gap_q == CNT_W'(1)) begin
						e_d     = '0;
						state_d = S_EMIT_RD;
					end else if (kidx_q == '0) begin
						gap_d = CNT_W'(1);
						i_d   = CNT_W'(1);
					end else begin
						kidx_d = kidx_dn;
						gap_d  = next_gap_w[CNT_W-1:0];
						i_d    = next_gap_w[CNT_W-1:0];
					end
				end else begin
					ram_raddr = i_q[ADDR_W-1:0];
					state_d   = S_HOLD;
				end
			end
			S_HOLD: begin
				held_d    = ram_rdata;
				j_d       = i_q[ADDR_W-1:0];
				ram_raddr = i_dn_w[ADDR_W-1:0];
				state_d   = S_CMP;
			end
			S_CMP: begin
				ram_we = 1'b1;
				if (step.less) begin
					// shift the larger element up by one gap
					ram_wdata = ram_rdata;
					j_d       = step.j_dn;
					if (step.j_dn_ge) begin
						ram_raddr = step.j_dn2;
					end else begin
						state_d = S_PUT;
					end
				end else begin
					i_d     = i_q + CNT_W'(1);
					state_d = S_NEXT;
				end
			end
			S_PUT: begin
				ram_we  = 1'b1;
				i_d     = i_q + CNT_W'(1);
				state_d = S_NEXT;
			end
			S_EMIT_RD: begin
				ram_raddr = e_q;
				state_d   = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				m_valid_d = 1'b1;
				m_data_d  = ram_rdata;
				m_last_d  = (CNT_W'(e_q) + CNT_W'(1)) == cnt_q;
				m_user_d  = ovf_q;
				state_d   = S_EMIT_OUT;
			end
			S_EMIT_OUT: begin
				if (m_tready) begin
					m_valid_d = 1'b0;
					if (m_last_q) begin
						cnt_d   = '0;
						ovf_d   = 1'b0;
						state_d = S_LOAD;
					end else begin
						e_d     = e_q + ADDR_W'(1);
						state_d = S_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	// output register
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

	// checks on the sequencer
	`SHSG_ASSERT_NOW(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(MAX_ITEMS), "count past capacity")
	`SHSG_ASSERT_NOW(a_walk_in_range, clk, arst_n, state_q == S_CMP, CNT_W'(j_q) >= gap_q, "insertion index below gap")
	`SHSG_ASSERT_NOW(a_no_rw_clash, clk, arst_n, state_q == S_CMP && step.less && step.j_dn_ge, ram_waddr != ram_raddr, "store read and write collide")
	`SHSG_ASSERT_NEXT(a_batch_clear, clk, arst_n, m_tvalid && m_tready && m_tlast, cnt_q == '0 && !ovf_q && state_q == S_LOAD, "batch state not cleared")

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// testbench for the shell sort unit: batch stimulus, sorted-result scoreboard and checks
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shsg_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 40;
	localparam int IDLE_PCT    = 34;
	localparam int RAND_ITEMS  = 90;

	// one sorted item as the block should emit it
	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     is_final;
		logic                     overflow;
	} sorted_item_t;

	// batch sorter model and queue of sorted items still owed by the block
	class sort_scoreboard;
		logic signed [DATA_W-1:0] batch_vals [MAX_ITEMS];
		int                       batch_len;
		bit                       dropped;
		sorted_item_t             owed_q [$];
		int                       errors;
		int                       batches;
		int                       ovf_batches;
		int                       checked;

		function new();
			batch_len   = 0;
			dropped     = 1'b0;
			errors      = 0;
			batches     = 0;
			ovf_batches = 0;
			checked     = 0;
		endfunction

		// sedgewick gap for index k, built from shifts
		function int unsigned gap_at(int unsigned k);
			return (32'd1 << (2 * k + 2)) + 3 * (32'd1 << k) + 1;
		endfunction

		// one gapped insertion pass over the batch
		function void gapped_pass(int n, int gap);
			logic signed [DATA_W-1:0] held;
			int j;
			for (int i = gap; i < n; i++) begin
				held = batch_vals[i];
				j = i;
				while (j >= gap && held < batch_vals[j - gap]) begin
					batch_vals[j] = batch_vals[j - gap];
					j -= gap;
				end
				batch_vals[j] = held;
			end
		endfunction

		// shell sort: largest gap below the count down to the smallest, then gap 1
		function void shell_sort(int n);
			int k;
			k = 0;
			while (k < 14 && gap_at(k) < n)
				k++;
			for (k = k - 1; k >= 0; k--)
				gapped_pass(n, gap_at(k));
			gapped_pass(n, 1);
		endfunction

		// accepted input item: store or drop, sort and queue results on the last one
		function void note_input(logic [DATA_W-1:0] v, logic last);
			sorted_item_t it;
			if (batch_len < MAX_ITEMS) begin
				batch_vals[batch_len] = v;
				batch_len++;
			end else begin
				dropped = 1'b1;
			end
			if (!last)
				return;
			shell_sort(batch_len);
			for (int k = 0; k < batch_len; k++) begin
				it.value    = batch_vals[k];
				it.is_final = (k == batch_len - 1);
				it.overflow = dropped;
				owed_q      = {owed_q, it};
			end
			batches++;
			if (dropped)
				ovf_batches++;
			batch_len = 0;
			dropped   = 1'b0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		// accepted result item against the oldest owed one
		task check_result(logic [DATA_W-1:0] d, logic l, logic u);
			sorted_item_t it;
			if (owed_q.size() == 0) begin
				report($sformatf("unexpected item %08h last=%0b ovf=%0b", d, l, u));
				return;
			end
			it = owed_q.pop_front();
			checked++;
			if (d !== it.value)
				report($sformatf("sorted_value %08h, want %08h", d, it.value));
			if (l !== it.is_final)
				report($sformatf("is_final %0b, want %0b (value %08h)", l, it.is_final, d));
			if (u !== it.overflow)
				report($sformatf("overflow %0b, want %0b (value %08h)", u, it.overflow, d));
		endtask

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              s_tlast  = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	bit             calm = 1'b0;
	int             cycles = 0;
	sort_scoreboard sb = new();

	shell_sort_sedgewick_gaps_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [31:0] value
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] sorted_value
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)    // [0] overflow
	);

	// clock
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items still owed", cycles, sb.pending());
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver stalls, none during the calm stretch
	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// handshake monitor: inputs into the model, results against it
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast, m_tuser);
	end

	// present one item with random gaps in front, hold until taken
	task automatic send_item(input logic [DATA_W-1:0] v, input logic last);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// value mix: extremes, a narrow band for duplicates, full random
	function automatic logic [DATA_W-1:0] pick_value();
		int band;
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: begin
				band = int'($urandom_range(0, 8)) - 4;
				return band;
			end
			default: return $urandom();
		endcase
	endfunction

	// stimulus
	initial begin
		logic [DATA_W-1:0] mixed_nine [9];
		int sent;
		int bsize;

		mixed_nine = '{32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
			32'h0000_0005, 32'h0000_0005, 32'hffff_fffb, 32'h0000_0001, 32'h7fff_ffff};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// single item batch at the most negative value
		send_item(32'h8000_0000, 1'b1);
		// two items, extremes in reverse order
		send_item(32'h7fff_ffff, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		// nine items: gap 8 pass runs, duplicates and both extremes
		for (int i = 0; i < 9; i++)
			send_item(mixed_nine[i], i == 8);
		// eight items descending: only the gap 1 pass
		for (int i = 0; i < 8; i++)
			send_item(7 - i, i == 7);

		// random batches: first one overruns the store and drops the items past capacity
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent == 0)
				bsize = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 3);
			else if ($urandom_range(0, 7) == 0)
				bsize = $urandom_range(24, MAX_ITEMS);
			else
				bsize = $urandom_range(1, 12);
			// keep the total near the planned item count
			if (sent != 0 && sent + bsize > RAND_ITEMS)
				bsize = RAND_ITEMS - sent;
			for (int i = 0; i < bsize; i++) begin
				calm = (sent >= 40 && sent < 80);
				send_item(pick_value(), i == bsize - 1);
				sent++;
			end
		end
		calm = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain, then a short quiet window for stray results
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d batches (%0d overrunning the store), %0d sorted items checked",
			sb.batches, sb.ovf_batches, sb.checked);
		$display("%0d random items after the directed batches, %0d mismatches",
			sent, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
